[sv/bth_pkg.sv]
`timescale 1ns / 1ps
// Package for the boundary-tag heap allocator: sequencer states, status codes, size
// constants and the memory control struct. No dependencies.
package bth_pkg;

  typedef enum logic [4:0] {
    ST_INIT, ST_INIT2, ST_IDLE, ST_S_RD, ST_S_CHK, ST_GROW, ST_G_RD, ST_G_CHK,
    ST_PLACE, ST_WR, ST_RESP_A, ST_RESP_F, ST_F_RD, ST_F_CHK, ST_M_RD1,
    ST_M_RD2, ST_M_CHK
  } state_t;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam int MIN_BLOCK = 16;
  localparam int WQ_DEPTH  = 4;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

[sv/bth_mem.sv]
`timescale 1ns / 1ps
// Single-port heap word memory, byte addressed, with a registered read.
// Depends on bth_pkg for the control struct.
module bth_mem #(
  parameter int HEAP_WORDS = 16384,
  parameter int BW = 18
) (
  input  logic              clk,
  input  bth_pkg::mem_ctl_t mc,
  input  logic [BW-1:0]     addr,
  input  logic [31:0]       wdata,
  output logic [31:0]       rdata
);

  localparam int IW = $clog2(HEAP_WORDS);
  localparam logic [BW-1:0] HEAP_BYTES = BW'(HEAP_WORDS * 4);

  logic [31:0] mem [HEAP_WORDS];
  logic        in_rng;

  assign in_rng = addr < HEAP_BYTES;

  always_ff @(posedge clk) begin
    if (mc.we && in_rng) begin
      mem[addr[IW+1:2]] <= wdata;
    end
    if (mc.re) begin
      rdata <= in_rng ? mem[addr[IW+1:2]] : 32'd0;
    end
  end

endmodule

[sv/bth_ctrl.sv]
`timescale 1ns / 1ps
// Allocator sequencer: heap layout, first-fit walk, break growth, split and
// coalesce, with a small write queue in front of the heap memory. Uses bth_pkg.
module bth_ctrl #(
  parameter int HEAP_WORDS = 16384,
  parameter int CHUNK_BYTES = 4096,
  parameter int BW = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_func,
  input  logic [15:0]       in_req_size,
  input  logic [15:0]       in_block_addr,
  output logic              out_valid,
  output logic [15:0]       out_payload_addr,
  output logic [1:0]        out_status,
  output bth_pkg::mem_ctl_t mc,
  output logic [BW-1:0]     m_addr,
  output logic [31:0]       m_wdata,
  input  logic [31:0]       m_rdata
);

  localparam int HB_INT = HEAP_WORDS * 4;
  localparam int CHUNK_SZ = ((CHUNK_BYTES >> 3) + ((CHUNK_BYTES >> 2) & 1)) << 3;
  localparam bit INIT_FITS = CHUNK_SZ <= HB_INT - 16;
  localparam logic [BW-1:0] HEAP_BYTES = BW'(HB_INT);
  localparam logic [BW-1:0] CSZ = BW'(CHUNK_SZ);
  localparam logic [BW-1:0] CHUNK = BW'(CHUNK_BYTES);
  localparam logic [BW-1:0] MINB = BW'(bth_pkg::MIN_BLOCK);

  bth_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [BW-1:0] bp_r, bp_nxt, brk_r, brk_nxt, asz_r, asz_nxt;
  logic [BW-1:0] c_r, c_nxt, sz_r, sz_nxt;
  logic [31:0]   prv_r, prv_nxt;
  logic [BW-1:0] wa_r [bth_pkg::WQ_DEPTH];
  logic [BW-1:0] wa_nxt [bth_pkg::WQ_DEPTH];
  logic [31:0]   wd_r [bth_pkg::WQ_DEPTH];
  logic [31:0]   wd_nxt [bth_pkg::WQ_DEPTH];
  logic [2:0]    wn_r, wn_nxt;
  logic          ov_r, ov_nxt;
  logic [15:0]   op_r, op_nxt;
  logic [1:0]    os_r, os_nxt;

  logic [BW-1:0] h_sz, p_sz, n_sz, a16, n_g, g_sz, t;
  logic [16:0]   rsum;
  logic          h_al, p_al;

  assign h_sz = {m_rdata[BW-1:3], 3'b000};
  assign h_al = m_rdata[0];
  assign p_sz = {prv_r[BW-1:3], 3'b000};
  assign p_al = prv_r[0];
  assign n_sz = h_sz;
  assign rsum = {1'b0, in_req_size} + 17'd15;
  assign a16  = BW'({rsum[16:3], 3'b000});
  assign n_g  = (asz_r > CHUNK) ? asz_r : CHUNK;
  assign g_sz = {n_g[BW-1:3] + (BW-3)'(n_g[2]), 3'b000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bth_pkg::ST_INIT;
      ret_r   <= bth_pkg::ST_IDLE;
      wn_r    <= 3'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      wn_r    <= wn_nxt;
      ov_r    <= ov_nxt;
    end
    bp_r  <= bp_nxt;
    brk_r <= brk_nxt;
    asz_r <= asz_nxt;
    c_r   <= c_nxt;
    sz_r  <= sz_nxt;
    prv_r <= prv_nxt;
    wa_r  <= wa_nxt;
    wd_r  <= wd_nxt;
    op_r  <= op_nxt;
    os_r  <= os_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    bp_nxt    = bp_r;
    brk_nxt   = brk_r;
    asz_nxt   = asz_r;
    c_nxt     = c_r;
    sz_nxt    = sz_r;
    prv_nxt   = prv_r;
    wa_nxt    = wa_r;
    wd_nxt    = wd_r;
    wn_nxt    = wn_r;
    ov_nxt    = 1'b0;
    op_nxt    = op_r;
    os_nxt    = os_r;
    mc        = '0;
    m_addr    = wa_r[0];
    m_wdata   = wd_r[0];
    t         = '0;
    case (state_r)
      bth_pkg::ST_INIT: begin
        wa_nxt[0] = BW'(0);  wd_nxt[0] = 32'd0;
        wa_nxt[1] = BW'(4);  wd_nxt[1] = 32'd9;
        wa_nxt[2] = BW'(8);  wd_nxt[2] = 32'd9;
        wa_nxt[3] = BW'(12); wd_nxt[3] = 32'd1;
        wn_nxt    = 3'd4;
        brk_nxt   = BW'(16);
        ret_nxt   = bth_pkg::ST_INIT2;
        state_nxt = bth_pkg::ST_WR;
      end
      bth_pkg::ST_INIT2: begin
        if (INIT_FITS) begin
          wa_nxt[0] = BW'(12);               wd_nxt[0] = 32'(CSZ);
          wa_nxt[1] = BW'(16) + CSZ - BW'(8); wd_nxt[1] = 32'(CSZ);
          wa_nxt[2] = BW'(16) + CSZ - BW'(4); wd_nxt[2] = 32'd1;
          wn_nxt    = 3'd3;
          brk_nxt   = BW'(16) + CSZ;
          ret_nxt   = bth_pkg::ST_IDLE;
          state_nxt = bth_pkg::ST_WR;
        end else begin
          state_nxt = bth_pkg::ST_IDLE;
        end
      end
      bth_pkg::ST_IDLE: begin
        if (start) begin
          if (!in_func) begin
            if (in_req_size == 16'd0) begin
              ov_nxt = 1'b1;
              op_nxt = 16'd0;
              os_nxt = bth_pkg::STAT_ZERO;
            end else begin
              asz_nxt   = (in_req_size <= 16'd8) ? MINB : a16;
              bp_nxt    = BW'(8);
              state_nxt = bth_pkg::ST_S_RD;
            end
          end else if (in_block_addr[2:0] == 3'd0 && in_block_addr >= 16'd16 &&
                       BW'(in_block_addr) < brk_r) begin
            bp_nxt    = BW'(in_block_addr);
            state_nxt = bth_pkg::ST_F_RD;
          end else begin
            ov_nxt = 1'b1;
            op_nxt = 16'd0;
            os_nxt = bth_pkg::STAT_DONE;
          end
        end
      end
      bth_pkg::ST_S_RD: begin
        if (bp_r < brk_r) begin
          mc.re     = 1'b1;
          m_addr    = bp_r - BW'(4);
          state_nxt = bth_pkg::ST_S_CHK;
        end else begin
          state_nxt = bth_pkg::ST_GROW;
        end
      end
      bth_pkg::ST_S_CHK: begin
        if (h_sz == '0) begin
          state_nxt = bth_pkg::ST_GROW;
        end else if (!h_al && asz_r <= h_sz) begin
          c_nxt     = h_sz;
          state_nxt = bth_pkg::ST_PLACE;
        end else if (h_sz >= brk_r - bp_r) begin
          state_nxt = bth_pkg::ST_GROW;
        end else begin
          bp_nxt    = bp_r + h_sz;
          state_nxt = bth_pkg::ST_S_RD;
        end
      end
      bth_pkg::ST_GROW: begin
        if (g_sz > HEAP_BYTES - brk_r) begin
          ov_nxt    = 1'b1;
          op_nxt    = 16'd0;
          os_nxt    = bth_pkg::STAT_FULL;
          state_nxt = bth_pkg::ST_IDLE;
        end else begin
          wa_nxt[0] = brk_r - BW'(4);          wd_nxt[0] = 32'(g_sz);
          wa_nxt[1] = brk_r + g_sz - BW'(8);   wd_nxt[1] = 32'(g_sz);
          wa_nxt[2] = brk_r + g_sz - BW'(4);   wd_nxt[2] = 32'd1;
          wn_nxt    = 3'd3;
          bp_nxt    = brk_r;
          brk_nxt   = brk_r + g_sz;
          sz_nxt    = g_sz;
          c_nxt     = g_sz;
          ret_nxt   = bth_pkg::ST_G_RD;
          state_nxt = bth_pkg::ST_WR;
        end
      end
      bth_pkg::ST_G_RD: begin
        mc.re     = 1'b1;
        m_addr    = bp_r - BW'(8);
        state_nxt = bth_pkg::ST_G_CHK;
      end
      bth_pkg::ST_G_CHK: begin
        if (h_al) begin
          state_nxt = bth_pkg::ST_PLACE;
        end else begin
          // merge the new space into the free block below the old break
          t         = sz_r + h_sz;
          wa_nxt[0] = bp_r - h_sz - BW'(4); wd_nxt[0] = 32'(t);
          wa_nxt[1] = bp_r + sz_r - BW'(8); wd_nxt[1] = 32'(t);
          wn_nxt    = 3'd2;
          bp_nxt    = bp_r - h_sz;
          c_nxt     = t;
          ret_nxt   = bth_pkg::ST_PLACE;
          state_nxt = bth_pkg::ST_WR;
        end
      end
      bth_pkg::ST_PLACE: begin
        t = c_r - asz_r;
        if (c_r >= asz_r + MINB) begin
          wa_nxt[0] = bp_r - BW'(4);          wd_nxt[0] = 32'(asz_r) | 32'd1;
          wa_nxt[1] = bp_r + asz_r - BW'(8);  wd_nxt[1] = 32'(asz_r) | 32'd1;
          wa_nxt[2] = bp_r + asz_r - BW'(4);  wd_nxt[2] = 32'(t);
          wa_nxt[3] = bp_r + c_r - BW'(8);    wd_nxt[3] = 32'(t);
          wn_nxt    = 3'd4;
        end else begin
          wa_nxt[0] = bp_r - BW'(4);          wd_nxt[0] = 32'(c_r) | 32'd1;
          wa_nxt[1] = bp_r + c_r - BW'(8);    wd_nxt[1] = 32'(c_r) | 32'd1;
          wn_nxt    = 3'd2;
        end
        ret_nxt   = bth_pkg::ST_RESP_A;
        state_nxt = bth_pkg::ST_WR;
      end
      bth_pkg::ST_WR: begin
        mc.we = 1'b1;
        for (int i = 0; i < bth_pkg::WQ_DEPTH - 1; i++) begin
          wa_nxt[i] = wa_r[i+1];
          wd_nxt[i] = wd_r[i+1];
        end
        wn_nxt = wn_r - 3'd1;
        if (wn_r <= 3'd1) begin
          state_nxt = ret_r;
        end
      end
      bth_pkg::ST_RESP_A: begin
        ov_nxt    = 1'b1;
        op_nxt    = bp_r[15:0];
        os_nxt    = bth_pkg::STAT_DONE;
        state_nxt = bth_pkg::ST_IDLE;
      end
      bth_pkg::ST_RESP_F: begin
        ov_nxt    = 1'b1;
        op_nxt    = 16'd0;
        os_nxt    = bth_pkg::STAT_DONE;
        state_nxt = bth_pkg::ST_IDLE;
      end
      bth_pkg::ST_F_RD: begin
        mc.re     = 1'b1;
        m_addr    = bp_r - BW'(4);
        state_nxt = bth_pkg::ST_F_CHK;
      end
      bth_pkg::ST_F_CHK: begin
        if (h_al && h_sz >= MINB && h_sz <= brk_r - bp_r) begin
          wa_nxt[0] = bp_r - BW'(4);         wd_nxt[0] = 32'(h_sz);
          wa_nxt[1] = bp_r + h_sz - BW'(8);  wd_nxt[1] = 32'(h_sz);
          wn_nxt    = 3'd2;
          sz_nxt    = h_sz;
          ret_nxt   = bth_pkg::ST_M_RD1;
          state_nxt = bth_pkg::ST_WR;
        end else begin
          state_nxt = bth_pkg::ST_RESP_F;
        end
      end
      bth_pkg::ST_M_RD1: begin
        mc.re     = 1'b1;
        m_addr    = bp_r - BW'(8);
        state_nxt = bth_pkg::ST_M_RD2;
      end
      bth_pkg::ST_M_RD2: begin
        prv_nxt   = m_rdata;
        mc.re     = 1'b1;
        m_addr    = bp_r + sz_r - BW'(4);
        state_nxt = bth_pkg::ST_M_CHK;
      end
      bth_pkg::ST_M_CHK: begin
        state_nxt = bth_pkg::ST_WR;
        ret_nxt   = bth_pkg::ST_RESP_F;
        wn_nxt    = 3'd2;
        if (p_al && h_al) begin
          wn_nxt    = 3'd0;
          state_nxt = bth_pkg::ST_RESP_F;
        end else if (p_al) begin
          t         = sz_r + n_sz;
          wa_nxt[0] = bp_r - BW'(4);                wd_nxt[0] = 32'(t);
          wa_nxt[1] = bp_r + t - BW'(8);            wd_nxt[1] = 32'(t);
        end else if (h_al) begin
          t         = sz_r + p_sz;
          wa_nxt[0] = bp_r - p_sz - BW'(4);         wd_nxt[0] = 32'(t);
          wa_nxt[1] = bp_r + sz_r - BW'(8);         wd_nxt[1] = 32'(t);
        end else begin
          t         = sz_r + p_sz + n_sz;
          wa_nxt[0] = bp_r - p_sz - BW'(4);         wd_nxt[0] = 32'(t);
          wa_nxt[1] = bp_r + sz_r + n_sz - BW'(8);  wd_nxt[1] = 32'(t);
        end
      end
      default: begin
        state_nxt = bth_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy             = state_r != bth_pkg::ST_IDLE;
  assign out_valid        = ov_r;
  assign out_payload_addr = op_r;
  assign out_status       = os_r;

endmodule

[sv/boundary_tag_heap_allocator_top.sv]
`timescale 1ns / 1ps
// First-fit boundary-tag heap allocator with a registered result beat. Allocate: a read and
// a check per header walked (one heap read port), then queued tag writes place the block;
// growing the break writes new tags first. Zero size: beat from idle. Free: header read and
// check, tag writes, neighbour reads, coalescing writes; a failed check ends it early, a bad
// address gets a beat from idle. One request at a time; busy stays high while in work.
// Synchronous reset, after which the initial layout is written. The receiver cannot stall.
module boundary_tag_heap_allocator_top #(
  parameter int HEAP_WORDS = 16384,
  parameter int CHUNK_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [15:0] in_req_size,
  input  logic [15:0] in_block_addr,
  output logic        out_valid,
  output logic [15:0] out_payload_addr,
  output logic [1:0]  out_status
);

  localparam int IW = $clog2(HEAP_WORDS);
  localparam int BW = (IW + 3 > 18) ? IW + 3 : 18;

  bth_pkg::mem_ctl_t mc;
  logic [BW-1:0]     m_addr;
  logic [31:0]       m_wdata, m_rdata;

  bth_ctrl #(.HEAP_WORDS(HEAP_WORDS), .CHUNK_BYTES(CHUNK_BYTES), .BW(BW)) u_ctrl (
    .clk, .rst_n, .start, .busy, .in_func, .in_req_size, .in_block_addr,
    .out_valid, .out_payload_addr, .out_status,
    .mc, .m_addr, .m_wdata, .m_rdata
  );

  bth_mem #(.HEAP_WORDS(HEAP_WORDS), .BW(BW)) u_mem (
    .clk, .mc, .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
  );

  a_stat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= bth_pkg::STAT_FULL) else $error("status out of range");

  a_idle_at_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bth_pkg::STAT_DONE |-> out_payload_addr == 16'd0)
    else $error("failed request with payload");

endmodule
